[sv/lpg_pkg.sv]
// lpg_pkg: shared types, widths and step codes for the line pixel generator
// no dependencies; imported by every lpg module and the top level

package lpg_pkg;

    localparam int COORD_BITS  = 10;
    localparam int CNT_BITS    = COORD_BITS + 1;
    localparam int ERR_BITS    = COORD_BITS + 1;
    localparam int COLOR_BITS  = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [CNT_BITS-1:0]   cnt_t;
    typedef logic [ERR_BITS-1:0]   err_t;
    typedef logic [COLOR_BITS-1:0] color_t;

    typedef enum logic [1:0] {
        STEP_NONE  = 2'd0,
        STEP_PLUS  = 2'd1,
        STEP_MINUS = 2'd3
    } step_t;

    localparam logic FUNC_START   = 1'b0;
    localparam logic FUNC_ADVANCE = 1'b1;

    // one classified request handed from the front to the back
    typedef struct packed {
        logic   is_start;
        logic   horiz;
        coord_t x;
        coord_t y;
        coord_t abs_dx;
        coord_t abs_dy;
        coord_t major;
        step_t  step_x;
        step_t  step_y;
        cnt_t   steps;
    } cmd_t;

    function automatic coord_t step_coord(input coord_t pos, input step_t step);
        coord_t res;
        case (step)
            STEP_PLUS:  res = pos + coord_t'(1);
            STEP_MINUS: res = pos - coord_t'(1);
            default:    res = pos;
        endcase
        return res;
    endfunction

endpackage

[sv/lpg_front.sv]
// lpg_front: accepts requests and works out the line setup for start requests
// depends on lpg_pkg

module lpg_front import lpg_pkg::*;
(
    input  logic   item_valid,
    output logic   item_stall,
    input  logic   func,
    input  coord_t x_start,
    input  coord_t y_start,
    input  coord_t x_end,
    input  coord_t y_end,
    input  logic   q_full,
    output logic   push,
    output cmd_t   cmd
);

    logic   x_gt;
    logic   x_lt;
    logic   y_gt;
    coord_t dx_abs;
    coord_t dy_abs;
    coord_t major;

    assign item_stall = q_full;
    assign push       = item_valid && !q_full;

    always_comb
    begin
        x_gt   = x_end > x_start;
        x_lt   = x_end < x_start;
        y_gt   = y_end > y_start;
        dx_abs = x_gt ? (x_end - x_start) : (x_start - x_end);
        dy_abs = y_gt ? (y_end - y_start) : (y_start - y_end);
        major  = (dx_abs > dy_abs) ? dx_abs : dy_abs;

        cmd          = '0;
        cmd.is_start = (func == FUNC_START);
        cmd.y        = y_start;
        cmd.abs_dx   = dx_abs;
        if (y_start == y_end)
        begin
            // horizontal: walk from the smaller x, inclusive of both ends
            cmd.horiz  = 1'b1;
            cmd.x      = x_gt ? x_start : x_end;
            cmd.abs_dy = '0;
            cmd.major  = dx_abs;
            cmd.step_x = STEP_PLUS;
            cmd.step_y = STEP_NONE;
            cmd.steps  = cnt_t'(dx_abs) + cnt_t'(1);
        end
        else
        begin
            cmd.horiz  = 1'b0;
            cmd.x      = x_start;
            cmd.abs_dy = dy_abs;
            cmd.major  = major;
            cmd.step_x = x_gt ? STEP_PLUS : (x_lt ? STEP_MINUS : STEP_NONE);
            cmd.step_y = y_gt ? STEP_PLUS : STEP_MINUS;
            // first point is emitted twice
            cmd.steps  = cnt_t'(major) + cnt_t'(2);
        end
    end

endmodule

[sv/lpg_queue.sv]
// lpg_queue: short fifo of classified requests between front and back
// depends on lpg_pkg

module lpg_queue import lpg_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic q_valid,
    output logic q_full,
    output cmd_t q_cmd
);

    cmd_t                 entry_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg;
    logic [QCNT_BITS-1:0] count_next;
    logic                 do_pop;

    assign q_valid = (count_reg != '0);
    assign q_full  = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign q_cmd   = entry_reg[rd_ptr_reg];
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + QPTR_BITS'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + QPTR_BITS'(1);
        end
        count_next = count_reg + QCNT_BITS'(push) - QCNT_BITS'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_BITS'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !push)
        else $error("push into full queue");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with unequal pointers");

endmodule

[sv/lpg_back.sv]
// lpg_back: line walker and pixel output register
// depends on lpg_pkg; fed by lpg_queue

module lpg_back import lpg_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   q_valid,
    input  cmd_t   q_cmd,
    output logic   pop,
    input  color_t fg_color,
    output logic   pixel_valid,
    input  logic   pixel_stall,
    output coord_t pixel_x,
    output coord_t pixel_y,
    output color_t pixel_color,
    output logic   last
);

    logic   active_reg,  active_next;
    logic   horiz_reg,   horiz_next;
    coord_t cur_x_reg,   cur_x_next;
    coord_t cur_y_reg,   cur_y_next;
    coord_t abs_dx_reg,  abs_dx_next;
    coord_t abs_dy_reg,  abs_dy_next;
    coord_t major_reg,   major_next;
    err_t   err_x_reg,   err_x_next;
    err_t   err_y_reg,   err_y_next;
    step_t  step_x_reg,  step_x_next;
    step_t  step_y_reg,  step_y_next;
    cnt_t   steps_reg,   steps_next;

    logic   pixel_valid_reg;
    coord_t pixel_x_reg;
    coord_t pixel_y_reg;
    color_t pixel_color_reg;
    logic   last_reg;

    logic   out_free;
    logic   emit;
    logic   is_last;
    err_t   ex_sum;
    err_t   ey_sum;
    logic   ex_step;
    logic   ey_step;

    assign out_free = !pixel_valid_reg || !pixel_stall;
    assign emit     = q_valid && !q_cmd.is_start && active_reg && out_free;
    // advance while idle is dropped without touching the output
    assign pop      = q_valid && (q_cmd.is_start || !active_reg || out_free);
    assign is_last  = (steps_reg <= cnt_t'(1));

    assign ex_sum  = err_x_reg + err_t'(abs_dx_reg);
    assign ey_sum  = err_y_reg + err_t'(abs_dy_reg);
    assign ex_step = ex_sum > err_t'(major_reg);
    assign ey_step = ey_sum > err_t'(major_reg);

    always_comb
    begin
        active_next = active_reg;
        horiz_next  = horiz_reg;
        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        abs_dx_next = abs_dx_reg;
        abs_dy_next = abs_dy_reg;
        major_next  = major_reg;
        err_x_next  = err_x_reg;
        err_y_next  = err_y_reg;
        step_x_next = step_x_reg;
        step_y_next = step_y_reg;
        steps_next  = steps_reg;

        if (pop && q_cmd.is_start)
        begin
            active_next = 1'b1;
            horiz_next  = q_cmd.horiz;
            cur_x_next  = q_cmd.x;
            cur_y_next  = q_cmd.y;
            abs_dx_next = q_cmd.abs_dx;
            abs_dy_next = q_cmd.abs_dy;
            major_next  = q_cmd.major;
            err_x_next  = '0;
            err_y_next  = '0;
            step_x_next = q_cmd.step_x;
            step_y_next = q_cmd.step_y;
            steps_next  = q_cmd.steps;
        end
        else if (emit)
        begin
            if (is_last)
            begin
                steps_next  = '0;
                active_next = 1'b0;
            end
            else
            begin
                steps_next = steps_reg - cnt_t'(1);
                if (horiz_reg)
                begin
                    cur_x_next = step_coord(cur_x_reg, step_x_reg);
                end
                else
                begin
                    err_x_next = ex_sum;
                    err_y_next = ey_sum;
                    if (ex_step)
                    begin
                        err_x_next = ex_sum - err_t'(major_reg);
                        cur_x_next = step_coord(cur_x_reg, step_x_reg);
                    end
                    if (ey_step)
                    begin
                        err_y_next = ey_sum - err_t'(major_reg);
                        cur_y_next = step_coord(cur_y_reg, step_y_reg);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg      <= 1'b0;
            horiz_reg       <= 1'b0;
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            abs_dx_reg      <= '0;
            abs_dy_reg      <= '0;
            major_reg       <= '0;
            err_x_reg       <= '0;
            err_y_reg       <= '0;
            step_x_reg      <= STEP_NONE;
            step_y_reg      <= STEP_NONE;
            steps_reg       <= '0;
            pixel_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            horiz_reg  <= horiz_next;
            cur_x_reg  <= cur_x_next;
            cur_y_reg  <= cur_y_next;
            abs_dx_reg <= abs_dx_next;
            abs_dy_reg <= abs_dy_next;
            major_reg  <= major_next;
            err_x_reg  <= err_x_next;
            err_y_reg  <= err_y_next;
            step_x_reg <= step_x_next;
            step_y_reg <= step_y_next;
            steps_reg  <= steps_next;
            if (emit)
            begin
                pixel_valid_reg <= 1'b1;
            end
            else if (!pixel_stall)
            begin
                pixel_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            pixel_x_reg     <= cur_x_reg;
            pixel_y_reg     <= cur_y_reg;
            pixel_color_reg <= fg_color;
            last_reg        <= is_last;
        end
    end

    assign pixel_valid = pixel_valid_reg;
    assign pixel_x     = pixel_x_reg;
    assign pixel_y     = pixel_y_reg;
    assign pixel_color = pixel_color_reg;
    assign last        = last_reg;

    a_active_has_steps: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (steps_reg != '0))
        else $error("active line with no steps left");

    a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && is_last) |=> !active_reg)
        else $error("line still active after last pixel");

    a_err_bound: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (err_x_reg <= err_t'(major_reg) && err_y_reg <= err_t'(major_reg)))
        else $error("error term above major distance");

    a_emit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_valid_reg && pixel_stall) |-> !emit)
        else $error("pixel overwritten while stalled");

endmodule

[sv/line_pixel_generator.sv]
// line_pixel_generator: top level, holds the foreground color register
// depends on lpg_pkg, lpg_front, lpg_queue, lpg_back
//
// usage:
//   request channel (item_valid / item_stall): func 0 loads a line from
//   x_start, y_start to x_end, y_end and gives no pixel; func 1 advances
//   and gives one pixel while a line is running, nothing when idle.
//   pixel channel (pixel_valid / pixel_stall): pixel_x, pixel_y, the
//   foreground color and last, which is set on the final pixel of a line.
//   cfg channel (cfg_valid / cfg_ready / cfg_data): writes the 16 bit
//   foreground color; cfg_ready is always high, write only while idle.
// timing:
//   an advance's pixel passes the request queue and the pixel output register
//   after its request is taken; one request per clock sustained while the
//   receiver does not stall. a two-entry request queue sits between the setup logic and the walker.
// reset: no line active, queue empty, foreground color zero.
// receiver stall: the pixel register holds, the walker stops taking advances
//   while a line runs, the queue fills and item_stall rises once it is full.

module line_pixel_generator import lpg_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   item_valid,
    output logic   item_stall,
    input  logic   func,
    input  coord_t x_start,
    input  coord_t y_start,
    input  coord_t x_end,
    input  coord_t y_end,
    output logic   pixel_valid,
    input  logic   pixel_stall,
    output coord_t pixel_x,
    output coord_t pixel_y,
    output color_t pixel_color,
    output logic   last,
    input  logic   cfg_valid,
    output logic   cfg_ready,
    input  color_t cfg_data
);

    color_t fg_color_reg;
    logic   push;
    cmd_t   push_cmd;
    logic   pop;
    logic   q_valid;
    logic   q_full;
    cmd_t   q_cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_color_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            fg_color_reg <= cfg_data;
        end
    end

    lpg_front u_front (
        .item_valid (item_valid),
        .item_stall (item_stall),
        .func       (func),
        .x_start    (x_start),
        .y_start    (y_start),
        .x_end      (x_end),
        .y_end      (y_end),
        .q_full     (q_full),
        .push       (push),
        .cmd        (push_cmd)
    );

    lpg_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_full   (q_full),
        .q_cmd    (q_cmd)
    );

    lpg_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_cmd       (q_cmd),
        .pop         (pop),
        .fg_color    (fg_color_reg),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_color (pixel_color),
        .last        (last)
    );

endmodule
